FILE: rtl/core/sde_pkg.sv
package sde_pkg;

   // Widths and counts of the SHA-1 datapath
   localparam int BLOCK_WORDS  = 16;
   localparam int ROUND_COUNT  = 80;
   localparam int DIGEST_WORDS = 5;

   typedef logic [31:0] word_type;
   typedef logic [6:0]  round_idx_type;
   typedef logic [5:0]  byte_pos_type;
   typedef logic [63:0] bit_len_type;
   typedef logic [2:0]  word_idx_type;
   typedef word_type [DIGEST_WORDS-1:0] chain_type;

   // Initial chaining words, h0 at index 0
   localparam chain_type CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                       32'hEFCDAB89, 32'h67452301};

   // Round constants and the first round of each group of twenty
   localparam word_type K_GROUP0 = 32'h5A827999;
   localparam word_type K_GROUP1 = 32'h6ED9EBA1;
   localparam word_type K_GROUP2 = 32'h8F1BBCDC;
   localparam word_type K_GROUP3 = 32'hCA62C1D6;
   localparam round_idx_type GROUP1_START = 7'd20;
   localparam round_idx_type GROUP2_START = 7'd40;
   localparam round_idx_type GROUP3_START = 7'd60;

   // Padding
   localparam logic [7:0]   PAD_BYTE = 8'h80;
   localparam byte_pos_type LEN_POS  = 6'd56;

   // Working variables a..e
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } round_regs_type;

   // Fixed taps of the schedule window
   typedef struct packed {
      word_type w0;
      word_type w2;
      word_type w8;
      word_type w13;
   } sched_taps_type;

   // Buffer commands from the sequencer
   typedef struct packed {
      logic put_byte;
      logic pad_tail;
      logic pad_len_only;
      logic shift;
   } buf_ctrl_type;

endpackage

FILE: rtl/core/sde_channels.sv
interface sde_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, output msg_byte, output has_byte, output last, input ready);
   modport sink (input valid, input msg_byte, input has_byte, input last, output ready);
endinterface

interface sde_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

FILE: rtl/core/sde_msg_buffer.sv
module sde_msg_buffer (
   input  logic                  clock,
   input  sde_pkg::buf_ctrl_type ctrl,
   input  sde_pkg::byte_pos_type byte_pos,
   input  logic [7:0]            msg_byte,
   input  sde_pkg::bit_len_type  bit_len,
   input  sde_pkg::word_type     sched_word,
   output sde_pkg::sched_taps_type taps
);

   sde_pkg::word_type win_ff [sde_pkg::BLOCK_WORDS];
   sde_pkg::word_type win_in [sde_pkg::BLOCK_WORDS];

   always_comb begin
      // advance the schedule window by one word
      for (int j = 0; j < sde_pkg::BLOCK_WORDS - 1; j++) begin
         win_in[j] = ctrl.shift ? win_ff[j+1] : win_ff[j];
      end
      win_in[sde_pkg::BLOCK_WORDS-1] = ctrl.shift ? sched_word
                                                  : win_ff[sde_pkg::BLOCK_WORDS-1];

      // byte writes and padding, big-endian within each word
      for (int j = 0; j < sde_pkg::BLOCK_WORDS; j++) begin
         for (int l = 0; l < 4; l++) begin
            if (ctrl.put_byte && byte_pos == sde_pkg::byte_pos_type'(j*4 + l)) begin
               win_in[j][31-8*l -: 8] = msg_byte;
            end
            if (ctrl.pad_tail) begin
               if (byte_pos == sde_pkg::byte_pos_type'(j*4 + l)) begin
                  win_in[j][31-8*l -: 8] = sde_pkg::PAD_BYTE;
               end else if (sde_pkg::byte_pos_type'(j*4 + l) > byte_pos) begin
                  win_in[j][31-8*l -: 8] = 8'h00;
               end
            end
            if (ctrl.pad_len_only) begin
               win_in[j][31-8*l -: 8] = 8'h00;
            end
         end
      end

      // place the bit length when it fits in this block
      if ((ctrl.pad_tail && byte_pos < sde_pkg::LEN_POS) || ctrl.pad_len_only) begin
         win_in[sde_pkg::BLOCK_WORDS-2] = bit_len[63:32];
         win_in[sde_pkg::BLOCK_WORDS-1] = bit_len[31:0];
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign taps.w0  = win_ff[0];
   assign taps.w2  = win_ff[2];
   assign taps.w8  = win_ff[8];
   assign taps.w13 = win_ff[13];

endmodule

FILE: rtl/core/sde_round.sv
module sde_round (
   input  sde_pkg::round_regs_type cur,
   input  sde_pkg::round_idx_type  round_idx,
   input  sde_pkg::sched_taps_type taps,
   output sde_pkg::round_regs_type nxt,
   output sde_pkg::word_type       sched_word
);

   sde_pkg::word_type f_val;
   sde_pkg::word_type k_val;
   sde_pkg::word_type mix;

   // select round function and constant by group
   always_comb begin
      if (round_idx < sde_pkg::GROUP1_START) begin
         f_val = (cur.b & cur.c) | (~cur.b & cur.d);
         k_val = sde_pkg::K_GROUP0;
      end else if (round_idx < sde_pkg::GROUP2_START) begin
         f_val = cur.b ^ cur.c ^ cur.d;
         k_val = sde_pkg::K_GROUP1;
      end else if (round_idx < sde_pkg::GROUP3_START) begin
         f_val = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
         k_val = sde_pkg::K_GROUP2;
      end else begin
         f_val = cur.b ^ cur.c ^ cur.d;
         k_val = sde_pkg::K_GROUP3;
      end
   end

   // one round: rotate a by 5 and add
   assign nxt.a = {cur.a[26:0], cur.a[31:27]} + f_val + cur.e + k_val + taps.w0;
   assign nxt.b = cur.a;
   assign nxt.c = {cur.b[1:0], cur.b[31:2]};
   assign nxt.d = cur.c;
   assign nxt.e = cur.d;

   // schedule word sixteen rounds ahead
   assign mix        = taps.w13 ^ taps.w8 ^ taps.w2 ^ taps.w0;
   assign sched_word = {mix[30:0], mix[31]};

endmodule

FILE: rtl/core/sha1_digest_engine.sv
// SHA-1 digest engine.
// req channel: one beat per message byte (msg_byte valid when has_byte is 1);
//   last marks the final beat of a message, with or without a byte.
// rsp channel: after a last beat, five beats carry digest words h0..h4,
//   word_index 0..4, last_word set on the fifth.
// Byte beats are taken while req.ready is high. The 64th byte of a block starts a
//   compression of 80 rounds on one shared round unit plus the chaining add,
//   during which req.ready is low.
// After last: a padding step and one compression, or two of each when fewer
//   than nine bytes of room remain in the block; then the five digest beats.
//   req.ready stays low until the fifth beat is taken.
// A stall on rsp holds the current digest word; nothing is lost.
// Reset (synchronous, active high) loads the initial chaining words and
//   clears the byte position and length; the engine is ready at once.
// After the digest the engine returns to the initial values by itself.
module sha1_digest_engine (
   input  logic            clock,
   input  logic            reset,
   sde_req_if.sink         req,
   sde_rsp_if.source       rsp
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_PAD2  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [1:0] PH_DATA  = 2'd0;
   localparam logic [1:0] PH_PAD1  = 2'd1;
   localparam logic [1:0] PH_FINAL = 2'd2;

   logic [2:0]                 state_ff, state_in;
   logic [1:0]                 phase_ff, phase_in;
   logic                       fin_ff, fin_in;
   sde_pkg::byte_pos_type      pos_ff, pos_in;
   logic [60:0]                cnt_ff, cnt_in;
   sde_pkg::chain_type         chain_ff, chain_in;
   sde_pkg::round_regs_type    regs_ff, regs_in;
   sde_pkg::round_idx_type     round_ff, round_in;
   sde_pkg::word_idx_type      word_idx_ff, word_idx_in;

   sde_pkg::buf_ctrl_type      buf_ctrl;
   sde_pkg::sched_taps_type    taps;
   sde_pkg::word_type          sched_word;
   sde_pkg::round_regs_type    round_nxt;
   sde_pkg::round_regs_type    chain_regs;
   logic                       req_fire;
   logic                       rsp_fire;

   sde_msg_buffer u_buffer (
      .clock      (clock),
      .ctrl       (buf_ctrl),
      .byte_pos   (pos_ff),
      .msg_byte   (req.msg_byte),
      .bit_len    ({cnt_ff, 3'b000}),
      .sched_word (sched_word),
      .taps       (taps)
   );

   sde_round u_round (
      .cur        (regs_ff),
      .round_idx  (round_ff),
      .taps       (taps),
      .nxt        (round_nxt),
      .sched_word (sched_word)
   );

   // handshakes
   assign req.ready       = (state_ff == ST_IDLE);
   assign req_fire        = req.valid && req.ready;
   assign rsp.valid       = (state_ff == ST_OUT);
   assign rsp.digest_word = chain_ff[word_idx_ff];
   assign rsp.word_index  = word_idx_ff;
   assign rsp.last_word   = (word_idx_ff == sde_pkg::word_idx_type'(sde_pkg::DIGEST_WORDS - 1));
   assign rsp_fire        = rsp.valid && rsp.ready;

   // working variables loaded from the chaining words
   assign chain_regs = '{a: chain_ff[0], b: chain_ff[1], c: chain_ff[2],
                         d: chain_ff[3], e: chain_ff[4]};

   // sequencer
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      chain_in    = chain_ff;
      regs_in     = regs_ff;
      round_in    = round_ff;
      word_idx_in = word_idx_ff;
      buf_ctrl    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               fin_in   = req.last;
               phase_in = PH_DATA;
               if (req.has_byte) begin
                  buf_ctrl.put_byte = 1'b1;
                  pos_in = pos_ff + 6'd1;
                  cnt_in = cnt_ff + 61'd1;
               end
               // full block compresses first, padding follows if marked
               if (req.has_byte && pos_ff == 6'd63) begin
                  state_in = ST_ROUND;
                  regs_in  = chain_regs;
                  round_in = '0;
               end else if (req.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            buf_ctrl.shift = 1'b1;
            regs_in  = round_nxt;
            round_in = round_ff + 7'd1;
            if (round_ff == sde_pkg::round_idx_type'(sde_pkg::ROUND_COUNT - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + regs_ff.a;
            chain_in[1] = chain_ff[1] + regs_ff.b;
            chain_in[2] = chain_ff[2] + regs_ff.c;
            chain_in[3] = chain_ff[3] + regs_ff.d;
            chain_in[4] = chain_ff[4] + regs_ff.e;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else begin
               case (phase_ff)
                  PH_DATA:  state_in = ST_PAD;
                  PH_PAD1:  state_in = ST_PAD2;
                  default: begin
                     state_in    = ST_OUT;
                     word_idx_in = '0;
                  end
               endcase
            end
         end
         ST_PAD: begin
            buf_ctrl.pad_tail = 1'b1;
            phase_in = (pos_ff < sde_pkg::LEN_POS) ? PH_FINAL : PH_PAD1;
            state_in = ST_ROUND;
            regs_in  = chain_regs;
            round_in = '0;
         end
         ST_PAD2: begin
            buf_ctrl.pad_len_only = 1'b1;
            phase_in = PH_FINAL;
            state_in = ST_ROUND;
            regs_in  = chain_regs;
            round_in = '0;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               word_idx_in = word_idx_ff + 3'd1;
               // digest out: drop back to the initial values
               if (rsp.last_word) begin
                  state_in = ST_IDLE;
                  chain_in = sde_pkg::CHAIN_INIT;
                  pos_in   = '0;
                  cnt_in   = '0;
                  fin_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_DATA;
         fin_ff      <= 1'b0;
         pos_ff      <= '0;
         cnt_ff      <= '0;
         chain_ff    <= sde_pkg::CHAIN_INIT;
         round_ff    <= '0;
         word_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         fin_ff      <= fin_in;
         pos_ff      <= pos_in;
         cnt_ff      <= cnt_in;
         chain_ff    <= chain_in;
         round_ff    <= round_in;
         word_idx_ff <= word_idx_in;
      end
   end

   // working variables
   always_ff @(posedge clock) begin
      regs_ff <= regs_in;
   end

   // engine never takes a byte while a digest is pending
   a_busy_on_output: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("req ready while digest pending");

   // round counter stays inside the eighty rounds
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff < 7'd80))
      else $error("round counter out of range");

   // digest word index stays in range and last_word marks word four
   a_word_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.word_index <= 3'd4) && (rsp.last_word == (rsp.word_index == 3'd4)))
      else $error("bad digest word index");

   // final digest beat frees the engine for the next message
   a_ready_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last_word) |=> req.ready && (pos_ff == 6'd0))
      else $error("engine not restarted after digest");

endmodule

FILE: dv/sha1_digest_engine_checker.sv
`timescale 1ns / 100ps

module sha1_digest_engine_checker (
   input  logic  clock,
   input  logic  reset,
   sde_req_if    req_mon,
   sde_rsp_if    rsp_mon,
   output int    mismatch_total,
   output int    digest_words_due,
   output int    digest_words_checked
);

   typedef logic [4:0][31:0] chain_words_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   localparam chain_words_type SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                          32'hEFCDAB89, 32'h67452301};
   localparam logic [31:0] ROUND_K0 = 32'h5A827999;
   localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
   localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
   localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_MARK = 8'h80;
   localparam int          LEN_OFFSET = 56;

   // Predicted engine state: chaining words, block bytes (byte 0 in the top bits)
   chain_words_type  chain_h;
   logic [511:0]     blk_bytes;
   logic [5:0]       fill_pos;
   logic [63:0]      msg_bits;
   digest_beat_type  digest_due[$];

   // One 80-round compression of a 64-byte block into the chaining words
   function automatic chain_words_type sha1_compress(input chain_words_type h,
                                                     input logic [511:0] blk);
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, k, mix, sum;
      for (int t = 0; t < 16; t++)
         sched[t] = blk[511 - 32*t -: 32];
      a = h[0];
      b = h[1];
      c = h[2];
      d = h[3];
      e = h[4];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            mix = sched[(t-3)%16] ^ sched[(t-8)%16] ^ sched[(t-14)%16] ^ sched[t%16];
            sched[t%16] = {mix[30:0], mix[31]};
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = ROUND_K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = ROUND_K1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = ROUND_K2;
         end else begin
            f = b ^ c ^ d;
            k = ROUND_K3;
         end
         sum = {a[26:0], a[31:27]} + f + e + k + sched[t%16];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      h[0] = h[0] + a;
      h[1] = h[1] + b;
      h[2] = h[2] + c;
      h[3] = h[3] + d;
      h[4] = h[4] + e;
      return h;
   endfunction

   // Take one request beat; on the end mark pad, finish and queue the digest
   task automatic sha1_absorb(input logic [7:0] data, input logic has_data,
                              input logic end_mark);
      int pos;
      digest_beat_type beat;
      if (has_data) begin
         blk_bytes[511 - 8*fill_pos -: 8] = data;
         fill_pos = fill_pos + 6'd1;
         msg_bits = msg_bits + 64'd8;
         if (fill_pos == 6'd0)
            chain_h = sha1_compress(chain_h, blk_bytes);
      end
      if (end_mark) begin
         pos = fill_pos;
         blk_bytes[511 - 8*pos -: 8] = PAD_MARK;
         pos++;
         // No room for the length: close this block and pad a fresh one
         if (pos > LEN_OFFSET) begin
            while (pos < 64) begin
               blk_bytes[511 - 8*pos -: 8] = 8'h00;
               pos++;
            end
            chain_h = sha1_compress(chain_h, blk_bytes);
            pos = 0;
         end
         while (pos < LEN_OFFSET) begin
            blk_bytes[511 - 8*pos -: 8] = 8'h00;
            pos++;
         end
         blk_bytes[63:0] = msg_bits;
         chain_h = sha1_compress(chain_h, blk_bytes);
         // queue the five digest beats in order
         for (int n = 0; n < 5; n++) begin
            beat.digest_word = chain_h[n];
            beat.word_index  = 3'(n);
            beat.last_word   = (n == 4);
            digest_due = {digest_due, beat};
         end
         chain_h  = SHA1_IV;
         fill_pos = '0;
         msg_bits = '0;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] digest mismatch: %s", $realtime, what);
      mismatch_total++;
   endtask

   // Watch both channels at each rising edge
   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         chain_h   = SHA1_IV;
         blk_bytes = '0;
         fill_pos  = '0;
         msg_bits  = '0;
         digest_due.delete();
      end else begin
         // compare each digest beat with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            digest_words_checked++;
            if (digest_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h index %0d last %b",
                  rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.last_word));
            end else begin
               want = digest_due.pop_front();
               if (rsp_mon.digest_word !== want.digest_word ||
                   rsp_mon.word_index !== want.word_index ||
                   rsp_mon.last_word !== want.last_word) begin
                  report_mismatch($sformatf("got %h/%0d/%b, expected %h/%0d/%b",
                     rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.last_word,
                     want.digest_word, want.word_index, want.last_word));
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            sha1_absorb(req_mon.msg_byte, req_mon.has_byte, req_mon.last);
      end
      digest_words_due = digest_due.size();
   end

endmodule

FILE: dv/sha1_digest_engine_tb.sv
`timescale 1ns / 100ps

module sha1_digest_engine_tb;

   localparam int QUIET_LIMIT = 3000;
   localparam int TAIL_CYCLES = 200;
   localparam int PHASE_BEATS = 100;

   logic clock = 1'b0;
   logic reset;

   sde_req_if req_bus ();
   sde_rsp_if rsp_bus ();

   int mismatches;
   int words_due;
   int words_checked;

   int send_idle_pct;
   int recv_idle_pct;
   int beats_sent;
   int messages_sent;
   int quiet_cycles;
   logic req_taken;

   int boundary_len [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   sha1_digest_engine dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   sha1_digest_engine_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_mon              (req_bus),
      .rsp_mon              (rsp_bus),
      .mismatch_total       (mismatches),
      .digest_words_due     (words_due),
      .digest_words_checked (words_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register request acceptance so the sender reads it at the falling edge
   always @(posedge clock) begin
      req_taken <= req_bus.valid && req_bus.ready;
   end

   // Digest receiver: stall at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d digest words outstanding",
                  quiet_cycles, words_due);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Drive one request beat; return at the falling edge after it is taken
   task automatic send_beat(input logic [7:0] data, input logic has_data,
                            input logic end_mark);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.msg_byte <= data;
      req_bus.has_byte <= has_data;
      req_bus.last     <= end_mark;
      do @(negedge clock); while (!req_taken);
      if (has_data || end_mark)
         beats_sent++;
      if (end_mark)
         messages_sent++;
   endtask

   // Hold the request side until every predicted digest word has arrived
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (words_due != 0);
   endtask

   // One message of random bytes; the end mark rides the last byte or a tail beat
   task automatic send_message(input int len);
      bit split_tail;
      split_tail = (len == 0) || ($urandom_range(9) < 3);
      for (int n = 0; n < len; n++) begin
         if ($urandom_range(15) == 0)
            send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(8'($urandom), 1'b1, !split_tail && (n == len - 1));
      end
      if (split_tail)
         send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   // Mostly short messages, some at the padding boundaries, a few multi-block
   function automatic int pick_length();
      int sel;
      sel = $urandom_range(99);
      if (sel < 75)
         return $urandom_range(24);
      else if (sel < 93)
         return boundary_len[$urandom_range(9)];
      else
         return $urandom_range(192, 130);
   endfunction

   initial begin
      int phase_goal;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.msg_byte = 8'h00;
      req_bus.has_byte = 1'b0;
      req_bus.last     = 1'b0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      beats_sent       = 0;
      messages_sent    = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty step, empty message, extreme bytes, byte with end mark
      send_beat(8'hA5, 1'b0, 1'b0);
      send_beat(8'h3C, 1'b0, 1'b1);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'h55, 1'b0, 1'b0);
      send_beat(8'h80, 1'b1, 1'b0);
      send_beat(8'h7F, 1'b1, 1'b1);
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
      send_beat(8'h00, 1'b0, 1'b1);
      hold_until_drained();

      // Random messages in three idle profiles
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_goal = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_goal) begin
            send_message(pick_length());
            if ($urandom_range(7) == 0)
               hold_until_drained();
         end
         hold_until_drained();
      end

      // Drain and let the engine settle
      req_bus.valid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Run covered %0d message beats in %0d messages, with empty, single-byte,",
               beats_sent, messages_sent);
      $display("block-boundary and multi-block lengths; %0d digest words compared, %0d bad",
               words_checked, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
